### rtl/sat_pkg.sv
package sat_pkg;

    localparam int OP_W    = 2;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int FIELD_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_BSEARCH = 2'd2,
        OP_LSEARCH = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_PUT,
        S_DEL_FIND,
        S_DEL_SHIFT,
        S_BIN,
        S_LIN,
        S_LIN_END
    } state_t;

endpackage

### rtl/sat_ram.sv
module sat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sorted_array_table.sv
// sorted table of signed 32-bit values kept in ascending order in one
// DEPTH-entry memory, with its length in a register. a command beat is taken
// when start is high and busy is low; opcode selects insert, delete, binary
// search or linear search of value. results come out as one-cycle pulses on
// valid with status, position, count and last; the receiver cannot hold
// them off, so it must take every pulse. insert and delete walk the memory
// one entry per cycle through its single read port: insert moves each larger
// entry up one place from the top (an empty or a full table is answered
// straight from idle), delete scans to the match, then closes the gap. binary
// search probes at most clog2(length)+1 entries. linear search reads every
// entry once and gives its match results as it scans; each match is held
// back until the next one or the end, so the final one can carry last. every
// command gives its first result no earlier than the cycle after it was
// taken. memory contents need no clearing: only entries below the length are
// ever read.
module sorted_array_table #(
    parameter int DEPTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [sat_pkg::OP_W-1:0]            opcode,
    input  logic signed [sat_pkg::VAL_W-1:0]    value,
    output logic                                busy,
    output logic                                valid,
    output logic [sat_pkg::STAT_W-1:0]          status,
    output logic [sat_pkg::FIELD_W-1:0]         position,
    output logic [sat_pkg::FIELD_W-1:0]         count,
    output logic                                last
);

    import sat_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    // control state
    state_t                     state_reg, state_next;
    logic [LW-1:0]              length_reg, length_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic [LW-1:0]              lo_reg, lo_next;
    logic [LW-1:0]              hx_reg, hx_next;
    logic                       pend_reg, pend_next;
    logic [FIELD_W-1:0]         pend_pos_reg, pend_pos_next;
    logic signed [VAL_W-1:0]    value_reg, value_next;

    // result register
    logic                       valid_reg, valid_next;
    status_t                    status_reg, status_next;
    logic [FIELD_W-1:0]         position_reg, position_next;
    logic [FIELD_W-1:0]         count_reg, count_next;
    logic                       last_reg, last_next;

    // memory port
    logic                       ram_we, ram_re;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic signed [VAL_W-1:0]    ram_wdata, ram_rdata;

    logic                       accept;
    op_t                        op_in;
    logic                       tbl_full, tbl_empty;
    logic [AW-1:0]              last_idx;
    logic [AW:0]                idx_plus;
    logic                       at_end;
    logic                       rd_eq, rd_gt, rd_lt;
    logic [LW-1:0]              lo_new, hx_new, bin_span;
    logic [AW-1:0]              mid_new, mid_first;
    logic                       bin_done;

    sat_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign op_in     = op_t'(opcode);
    assign tbl_full  = (length_reg == LW'(DEPTH));
    assign tbl_empty = (length_reg == '0);
    assign last_idx  = AW'(length_reg - 1'b1);
    assign idx_plus  = {1'b0, idx_reg} + 1'b1;
    assign at_end    = (idx_reg == last_idx);

    // compare of the entry read last cycle against the command value
    assign rd_eq = (ram_rdata == value_reg);
    assign rd_gt = (ram_rdata > value_reg);
    assign rd_lt = !rd_eq && !rd_gt;

    // binary search: half-open window [lo, hx)
    assign lo_new    = rd_lt ? LW'(idx_plus) : lo_reg;
    assign hx_new    = rd_lt ? hx_reg : LW'(idx_reg);
    assign bin_done  = (lo_new >= hx_new);
    assign bin_span  = hx_new - lo_new - 1'b1;
    assign mid_new   = AW'(lo_new + (bin_span >> 1));
    assign mid_first = AW'((length_reg - 1'b1) >> 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_in)
                        OP_INSERT:  state_next = (tbl_full || tbl_empty) ? S_IDLE : S_INS;
                        OP_DELETE:  state_next = tbl_empty ? S_IDLE : S_DEL_FIND;
                        OP_BSEARCH: state_next = tbl_empty ? S_IDLE : S_BIN;
                        OP_LSEARCH: state_next = tbl_empty ? S_IDLE : S_LIN;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_INS:
            begin
                if (rd_gt && idx_reg == '0)
                begin
                    state_next = S_INS_PUT;
                end
                else if (!rd_gt)
                begin
                    state_next = S_IDLE;
                end
            end
            S_INS_PUT:
            begin
                state_next = S_IDLE;
            end
            S_DEL_FIND:
            begin
                if (at_end)
                begin
                    state_next = S_IDLE;
                end
                else if (rd_eq)
                begin
                    state_next = S_DEL_SHIFT;
                end
            end
            S_DEL_SHIFT:
            begin
                if (at_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_BIN:
            begin
                if (rd_eq || bin_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LIN:
            begin
                if (at_end)
                begin
                    state_next = S_LIN_END;
                end
            end
            S_LIN_END:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath, memory control and results
    always_comb
    begin
        length_next   = length_reg;
        idx_next      = idx_reg;
        lo_next       = lo_reg;
        hx_next       = hx_reg;
        pend_next     = pend_reg;
        pend_pos_next = pend_pos_reg;
        value_next    = value_reg;
        valid_next    = 1'b0;
        status_next   = STAT_OK;
        position_next = '0;
        last_next     = 1'b1;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = value_reg;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next = value;
                    case (op_in)
                        OP_INSERT:
                        begin
                            if (tbl_full)
                            begin
                                valid_next  = 1'b1;
                                status_next = STAT_FULL;
                            end
                            else if (tbl_empty)
                            begin
                                // first entry goes straight in
                                ram_we      = 1'b1;
                                ram_waddr   = '0;
                                ram_wdata   = value;
                                length_next = length_reg + 1'b1;
                                valid_next  = 1'b1;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = last_idx;
                                idx_next  = last_idx;
                            end
                        end
                        OP_BSEARCH:
                        begin
                            if (tbl_empty)
                            begin
                                valid_next  = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                lo_next   = '0;
                                hx_next   = length_reg;
                                ram_re    = 1'b1;
                                ram_raddr = mid_first;
                                idx_next  = mid_first;
                            end
                        end
                        default:
                        begin
                            // delete and linear search both scan up from entry 0
                            if (tbl_empty)
                            begin
                                valid_next  = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                idx_next  = '0;
                                pend_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(idx_plus);
                if (rd_gt)
                begin
                    // move the larger entry up one place
                    ram_wdata = ram_rdata;
                    if (idx_reg != '0)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg - 1'b1;
                        idx_next  = idx_reg - 1'b1;
                    end
                end
                else
                begin
                    ram_wdata   = value_reg;
                    length_next = length_reg + 1'b1;
                    valid_next  = 1'b1;
                end
            end
            S_INS_PUT:
            begin
                ram_we      = 1'b1;
                ram_waddr   = '0;
                ram_wdata   = value_reg;
                length_next = length_reg + 1'b1;
                valid_next  = 1'b1;
            end
            S_DEL_FIND:
            begin
                if (rd_eq && at_end)
                begin
                    length_next = length_reg - 1'b1;
                    valid_next  = 1'b1;
                end
                else if (at_end)
                begin
                    valid_next  = 1'b1;
                    status_next = STAT_NOT_FOUND;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(idx_plus);
                    idx_next  = AW'(idx_plus);
                end
            end
            S_DEL_SHIFT:
            begin
                // close the gap: entry idx moves down one place
                ram_we    = 1'b1;
                ram_waddr = idx_reg - 1'b1;
                ram_wdata = ram_rdata;
                if (at_end)
                begin
                    length_next = length_reg - 1'b1;
                    valid_next  = 1'b1;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(idx_plus);
                    idx_next  = AW'(idx_plus);
                end
            end
            S_BIN:
            begin
                if (rd_eq)
                begin
                    valid_next    = 1'b1;
                    position_next = FIELD_W'(idx_plus);
                end
                else if (bin_done)
                begin
                    valid_next  = 1'b1;
                    status_next = STAT_NOT_FOUND;
                end
                else
                begin
                    lo_next   = lo_new;
                    hx_next   = hx_new;
                    ram_re    = 1'b1;
                    ram_raddr = mid_new;
                    idx_next  = mid_new;
                end
            end
            S_LIN:
            begin
                // hold each match back until the next one or the end, so the final one can carry last
                if (rd_eq)
                begin
                    pend_next     = 1'b1;
                    pend_pos_next = FIELD_W'(idx_plus);
                    if (pend_reg)
                    begin
                        valid_next    = 1'b1;
                        position_next = pend_pos_reg;
                        last_next     = 1'b0;
                    end
                end
                if (!at_end)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(idx_plus);
                    idx_next  = AW'(idx_plus);
                end
            end
            S_LIN_END:
            begin
                valid_next = 1'b1;
                if (pend_reg)
                begin
                    position_next = pend_pos_reg;
                end
                else
                begin
                    status_next = STAT_NOT_FOUND;
                end
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase

        count_next = FIELD_W'(length_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            length_reg   <= '0;
            idx_reg      <= '0;
            lo_reg       <= '0;
            hx_reg       <= '0;
            pend_reg     <= 1'b0;
            pend_pos_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            length_reg   <= length_next;
            idx_reg      <= idx_next;
            lo_reg       <= lo_next;
            hx_reg       <= hx_next;
            pend_reg     <= pend_next;
            pend_pos_reg <= pend_pos_next;
            valid_reg    <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        status_reg   <= status_next;
        position_reg <= position_next;
        count_reg    <= count_next;
        last_reg     <= last_next;
    end

    assign valid    = valid_reg;
    assign status   = status_reg;
    assign position = position_reg;
    assign count    = count_reg;
    assign last     = last_reg;

    // length never passes the table size
    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LW'(DEPTH))
        else $error("length beyond table size");

    // the shift walks never write the entry being read
    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("memory read and write hit the same entry");

    // a taken command either starts a walk or answers at once
    a_cmd_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || valid)
        else $error("command taken with no walk and no result");

    // only a linear search gives a result that is not its last, and it keeps going
    a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |-> status_reg == STAT_OK && busy)
        else $error("non-final result outside a linear search");

    // table full is reported only when the table really is full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status_reg == STAT_FULL |-> tbl_full)
        else $error("full status with room left");

endmodule

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sat_pkg::*;

    localparam int TBL_DEPTH      = 32;
    // quiet cycles allowed before the run is called hung; sender gaps are short
    localparam int WATCHDOG_LIMIT = 4000;
    // a linear search keeps the block busy while it reads every entry
    localparam int SETTLE_CYCLES  = 2 * TBL_DEPTH + 8;

    // one expected result beat
    typedef struct packed {
        status_t               status;
        logic [FIELD_W-1:0]    position;
        logic [FIELD_W-1:0]    count;
        logic                  last;
    } table_result_t;

    // predictor of the sorted table plus the queue of results it expects
    class sorted_table_model;
        logic signed [VAL_W-1:0] slots [TBL_DEPTH];
        int                      fill;
        table_result_t           pending_results [$];
        int                      errors;
        int                      n_checked;
        int                      n_full;
        int                      n_empty;
        int                      peak;
        int                      n_op [4];

        function new();
            fill = 0;
            errors = 0;
            n_checked = 0;
            n_full = 0;
            n_empty = 0;
            peak = 0;
            foreach (n_op[i])
                n_op[i] = 0;
        endfunction

        function void push(status_t st, int pos, bit fin);
            table_result_t r;
            r.status   = st;
            r.position = FIELD_W'(pos);
            r.count    = FIELD_W'(fill);
            r.last     = fin;
            pending_results.push_back(r);
        endfunction

        // works out the results of one accepted command and updates the table
        function void note_command(op_t op, logic signed [VAL_W-1:0] v);
            int i;
            int at;
            int lo;
            int hi;
            int mid;
            int hits;
            int k;
            bit found;
            n_op[op]++;
            if (op == OP_INSERT) begin
                if (fill >= TBL_DEPTH) begin
                    n_full++;
                    push(STAT_FULL, 0, 1'b1);
                end
                else begin
                    // equal values stay ahead of the new one
                    i = fill - 1;
                    while (i >= 0 && slots[i] > v) begin
                        slots[i + 1] = slots[i];
                        i--;
                    end
                    slots[i + 1] = v;
                    fill++;
                    if (fill > peak)
                        peak = fill;
                    push(STAT_OK, 0, 1'b1);
                end
            end
            else if (fill == 0) begin
                n_empty++;
                push(STAT_EMPTY, 0, 1'b1);
            end
            else if (op == OP_DELETE) begin
                at = -1;
                for (i = 0; i < fill; i++) begin
                    if (slots[i] == v) begin
                        at = i;
                        break;
                    end
                end
                if (at < 0)
                    push(STAT_NOT_FOUND, 0, 1'b1);
                else begin
                    for (i = at; i < fill - 1; i++)
                        slots[i] = slots[i + 1];
                    fill--;
                    push(STAT_OK, 0, 1'b1);
                end
            end
            else if (op == OP_BSEARCH) begin
                // first probed midpoint that matches wins
                lo = 0;
                hi = fill - 1;
                found = 1'b0;
                while (lo <= hi && !found) begin
                    mid = lo + (hi - lo) / 2;
                    if (slots[mid] == v) begin
                        push(STAT_OK, mid + 1, 1'b1);
                        found = 1'b1;
                    end
                    else if (slots[mid] < v)
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
                if (!found)
                    push(STAT_NOT_FOUND, 0, 1'b1);
            end
            else begin
                hits = 0;
                for (i = 0; i < fill; i++)
                    if (slots[i] == v)
                        hits++;
                if (hits == 0)
                    push(STAT_NOT_FOUND, 0, 1'b1);
                else begin
                    k = 0;
                    for (i = 0; i < fill; i++) begin
                        if (slots[i] == v) begin
                            k++;
                            push(STAT_OK, i + 1, k == hits);
                        end
                    end
                end
            end
        endfunction

        function logic signed [VAL_W-1:0] pick_entry();
            if (fill == 0)
                return '0;
            return slots[$urandom_range(fill - 1)];
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // compares one result beat with the oldest expectation
        task check_result(logic [STAT_W-1:0] st, logic [FIELD_W-1:0] pos,
                          logic [FIELD_W-1:0] cnt, logic fin);
            table_result_t e;
            n_checked++;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result status=%0d position=%0d count=%0d last=%0b",
                                 st, pos, cnt, fin));
                return;
            end
            e = pending_results.pop_front();
            if (st !== e.status)
                report($sformatf("status %0d, want %0d", st, e.status));
            if (pos !== e.position)
                report($sformatf("position %0d, want %0d", pos, e.position));
            if (cnt !== e.count)
                report($sformatf("count %0d, want %0d", cnt, e.count));
            if (fin !== e.last)
                report($sformatf("last %0b, want %0b", fin, e.last));
        endtask
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic [OP_W-1:0]            opcode = '0;
    logic signed [VAL_W-1:0]    value = '0;
    logic                       busy;
    logic                       valid;
    logic [STAT_W-1:0]          status;
    logic [FIELD_W-1:0]         position;
    logic [FIELD_W-1:0]         count;
    logic                       last;

    sorted_table_model sb = new();
    int quiet_cycles = 0;

    sorted_array_table #(
        .DEPTH(TBL_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .opcode(opcode),
        .value(value),
        .busy(busy),
        .valid(valid),
        .status(status),
        .position(position),
        .count(count),
        .last(last)
    );

    // 10 ns clock
    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    // result monitor: every strobed beat is checked at the edge that ends it
    always @(posedge clk)
    begin
        if (rst_n && valid === 1'b1)
            sb.check_result(status, position, count, last);
    end

    // watchdog: counts cycles with neither a command beat nor a result beat
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || valid === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, sb.pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // present one command and hold it until the block takes it;
    // returns at the accepting edge with start still high
    task automatic issue(op_t op, logic signed [VAL_W-1:0] v);
        start  <= 1'b1;
        opcode <= op;
        value  <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_command(op, v);
    endtask

    // random sender gap, geometric in length
    task automatic sender_gap(int gap_pct);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
    endtask

    // hold off until every expected result has come back
    task automatic wait_drained();
        if (sb.pending_results.size() != 0) begin
            start <= 1'b0;
            do
                @(posedge clk);
            while (sb.pending_results.size() != 0);
        end
    endtask

    // mostly small values so duplicates and hits are common, plus extremes
    function automatic logic signed [VAL_W-1:0] rand_value();
        int k;
        k = $urandom_range(99);
        if (k < 50)
            return VAL_W'(int'($urandom_range(6)) - 3);
        if (k < 65) begin
            case ($urandom_range(3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh8000_0001;
                default: return 32'sh7fff_fffe;
            endcase
        end
        return $urandom;
    endfunction

    function automatic op_t pick_op(int ins_pct, int del_pct);
        int r;
        r = $urandom_range(99);
        if (r < ins_pct)
            return OP_INSERT;
        if (r < ins_pct + del_pct)
            return OP_DELETE;
        return $urandom_range(1) ? OP_BSEARCH : OP_LSEARCH;
    endfunction

    // random commands: deletes and searches mostly aim at values held
    task automatic run_phase(int items, int ins_pct, int del_pct, int gap_pct);
        op_t op;
        logic signed [VAL_W-1:0] v;
        for (int n = 0; n < items; n++) begin
            op = pick_op(ins_pct, del_pct);
            if (op != OP_INSERT && $urandom_range(99) < 70)
                v = sb.pick_entry();
            else
                v = rand_value();
            issue(op, v);
            sender_gap(gap_pct);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lookups and delete on an empty table
        issue(OP_BSEARCH, 32'sd0);
        issue(OP_LSEARCH, 32'sd0);
        issue(OP_DELETE, 32'sd0);
        // extremes, and duplicates landing after their equals
        issue(OP_INSERT, 32'sd5);
        issue(OP_INSERT, 32'sh8000_0000);
        issue(OP_INSERT, 32'sh7fff_ffff);
        issue(OP_INSERT, 32'sd5);
        issue(OP_INSERT, -32'sd1);
        issue(OP_INSERT, 32'sd0);
        issue(OP_INSERT, 32'sd5);
        // repeated values: binary hits some midpoint, linear gives every match
        issue(OP_BSEARCH, 32'sd5);
        issue(OP_LSEARCH, 32'sd5);
        issue(OP_BSEARCH, 32'sh8000_0000);
        issue(OP_BSEARCH, 32'sh7fff_ffff);
        issue(OP_LSEARCH, 32'sh7fff_ffff);
        // absent value
        issue(OP_BSEARCH, 32'sd7);
        issue(OP_LSEARCH, 32'sd7);
        issue(OP_DELETE, 32'sd7);
        // removals at the bottom, middle and top
        issue(OP_DELETE, 32'sd5);
        issue(OP_DELETE, 32'sh8000_0000);
        issue(OP_LSEARCH, 32'sd5);
        issue(OP_DELETE, 32'sh7fff_ffff);
        wait_drained();

        // fill toward full with a lightly idling sender
        run_phase(40, 85, 5, 6);
        wait_drained();
        // mixed traffic with a heavily idling sender
        run_phase(32, 35, 30, 59);
        wait_drained();
        // drain toward empty back to back
        run_phase(45, 5, 80, 0);
        wait_drained();

        // let any trailing work finish and catch stray beats
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("ran %0d commands (%0d insert, %0d delete, %0d binary, %0d linear), %0d results",
                 sb.n_op[0] + sb.n_op[1] + sb.n_op[2] + sb.n_op[3], sb.n_op[0], sb.n_op[1],
                 sb.n_op[2], sb.n_op[3], sb.n_checked);
        $display("table peaked at %0d entries; %0d inserts hit a full table, %0d commands an empty one",
                 sb.peak, sb.n_full, sb.n_empty);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
